// ===== design/tfi_pkg.sv =====
package tfi_pkg;

    // Default field widths of the coordinate and fixed point formats.
    localparam int DEF_COORD_BITS = 10;
    localparam int DEF_FRAC_BITS  = 8;

    // Result displacement words are 19-bit two's complement.
    localparam int FLOW_W     = 19;
    localparam int FLOW_CAP   = (1 << (FLOW_W - 1)) - 1;
    localparam int M_TDATA_W  = 2 + 2 * FLOW_W;

    // Number of stored corners and depth of the front-to-back queue.
    localparam int NUM_CORNERS = 3;
    localparam int QUEUE_DEPTH = 4;

    // Item kinds carried on s_tuser.
    localparam logic OPC_LOAD  = 1'b0;
    localparam logic OPC_PIXEL = 1'b1;

    // Flags that travel with every item from the front to the back.
    typedef struct packed {
        logic pix;
        logic degen;
        logic in_tri;
    } item_flags_t;

    // Plane rebuild sequencer after a corner load.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIFF  = 6'b000010,
        ST_PROD  = 6'b000100,
        ST_ABC   = 6'b001000,
        ST_DPROD = 6'b010000,
        ST_DSUM  = 6'b100000
    } load_state_t;

endpackage

// ===== design/tfi_queue.sv =====
module tfi_queue
    import tfi_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           head_data,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer wrap and occupancy bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ===== design/tfi_front.sv =====
module tfi_front
    import tfi_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int QDEPTH     = QUEUE_DEPTH,
    parameter int AW         = 2 * DEF_COORD_BITS + 5,
    parameter int NW         = 3 * DEF_COORD_BITS + 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [1:0]                  vertex_slot,
    input  logic [COORD_BITS-1:0]       src_x,
    input  logic [COORD_BITS-1:0]       src_y,
    input  logic [COORD_BITS-1:0]       dst_x,
    input  logic [COORD_BITS-1:0]       dst_y,
    input  logic [COORD_BITS-1:0]       pixel_x,
    input  logic [COORD_BITS-1:0]       pixel_y,
    input  logic [$clog2(QDEPTH+1)-1:0] q_count,
    output logic                        push,
    output item_flags_t                 push_flags,
    output logic signed [NW-1:0]        push_nx,
    output logic signed [NW-1:0]        push_ny,
    output logic signed [AW-1:0]        push_c
);

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 2;
    localparam int TW    = AW + DW;
    localparam int PW    = TW + 2;
    localparam int EW    = 2 * DW + 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    // Zero-extend a coordinate into a signed difference-width word.
    function automatic logic signed [DW-1:0] ext(input logic [CB-1:0] v);
        return signed'(DW'(v));
    endfunction

    // Cross product of edge u->v with the vector from u to the pixel.
    function automatic logic signed [EW-1:0] edge_cross(
        input logic [CB-1:0] ux, input logic [CB-1:0] uy,
        input logic [CB-1:0] vx, input logic [CB-1:0] vy,
        input logic [CB-1:0] qx, input logic [CB-1:0] qy
    );
        logic signed [DW-1:0] ex, ey, rx, ry;
        ex = ext(vx) - ext(ux);
        ey = ext(vy) - ext(uy);
        rx = ext(qx) - ext(ux);
        ry = ext(qy) - ext(uy);
        return EW'(ex) * EW'(ry) - EW'(ey) * EW'(rx);
    endfunction

    // Corner store and plane terms.
    logic [CB-1:0]        sx_reg [NUM_CORNERS];
    logic [CB-1:0]        sy_reg [NUM_CORNERS];
    logic [CB-1:0]        dx_reg [NUM_CORNERS];
    logic [CB-1:0]        dy_reg [NUM_CORNERS];
    logic signed [AW-1:0] ax_reg, bx_reg, ay_reg, by_reg, c_reg;
    logic signed [PW-1:0] dpx_reg, dpy_reg;

    // Rebuild sequencer working registers.
    load_state_t            state_reg, state_next;
    logic signed [DW-1:0]   v1_reg, v2_reg, w1_reg, w2_reg;
    logic signed [DW-1:0]   v3x_reg, w3x_reg, v3y_reg, w3y_reg;
    logic signed [2*DW-1:0] pa1x_reg, pa2x_reg, pb1x_reg, pb2x_reg;
    logic signed [2*DW-1:0] pa1y_reg, pa2y_reg, pb1y_reg, pb2y_reg;
    logic signed [2*DW-1:0] pc1_reg, pc2_reg;
    logic signed [TW-1:0]   dax_reg, dbx_reg, dcx_reg, day_reg, dby_reg, dcy_reg;

    // Query pipeline stages.
    logic                 va_reg, a_pix_reg, a_degen_reg;
    logic [CB-1:0]        a_px_reg, a_py_reg;
    logic                 vb_reg, b_pix_reg, b_degen_reg;
    logic signed [TW-1:0] b_pax_reg, b_pby_reg, b_pay_reg, b_pby2_reg;
    logic signed [EW-1:0] b_e0_reg, b_e1_reg, b_e2_reg;

    logic                 accept;
    logic signed [DW-1:0] zx0, zx1, zx2, zy0, zy1, zy2;
    logic                 pos_all, neg_all;

    // Accept only when the sequencer is idle and every item in flight is sure of a queue slot.
    assign in_ready = (state_reg == ST_IDLE) &&
                      (({1'b0, q_count} + (CNT_W+1)'(va_reg) + (CNT_W+1)'(vb_reg))
                       < (CNT_W+1)'(QDEPTH));
    assign accept   = in_valid && in_ready;

    // Sequencer steps through the rebuild once per load.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept && opcode == OPC_LOAD) begin
                          state_next = ST_DIFF;
                      end
            ST_DIFF:  state_next = ST_PROD;
            ST_PROD:  state_next = ST_ABC;
            ST_ABC:   state_next = ST_DPROD;
            ST_DPROD: state_next = ST_DSUM;
            ST_DSUM:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Corner displacements.
    always_comb begin
        zx0 = ext(dx_reg[0]) - ext(sx_reg[0]);
        zx1 = ext(dx_reg[1]) - ext(sx_reg[1]);
        zx2 = ext(dx_reg[2]) - ext(sx_reg[2]);
        zy0 = ext(dy_reg[0]) - ext(sy_reg[0]);
        zy1 = ext(dy_reg[1]) - ext(sy_reg[1]);
        zy2 = ext(dy_reg[2]) - ext(sy_reg[2]);
    end

    // Control state, corner store and plane terms.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NUM_CORNERS; i++) begin
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
                dx_reg[i] <= '0;
                dy_reg[i] <= '0;
            end
            ax_reg  <= '0;
            bx_reg  <= '0;
            ay_reg  <= '0;
            by_reg  <= '0;
            c_reg   <= '0;
            dpx_reg <= '0;
            dpy_reg <= '0;
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && opcode == OPC_LOAD && vertex_slot < 2'(NUM_CORNERS)) begin
                sx_reg[vertex_slot] <= src_x;
                sy_reg[vertex_slot] <= src_y;
                dx_reg[vertex_slot] <= dst_x;
                dy_reg[vertex_slot] <= dst_y;
            end
            if (state_reg == ST_ABC) begin
                ax_reg <= AW'(pa1x_reg) - AW'(pa2x_reg);
                bx_reg <= AW'(pb1x_reg) - AW'(pb2x_reg);
                ay_reg <= AW'(pa1y_reg) - AW'(pa2y_reg);
                by_reg <= AW'(pb1y_reg) - AW'(pb2y_reg);
                c_reg  <= AW'(pc1_reg) - AW'(pc2_reg);
            end
            if (state_reg == ST_DSUM) begin
                dpx_reg <= -(PW'(dax_reg) + PW'(dbx_reg) + PW'(dcx_reg));
                dpy_reg <= -(PW'(day_reg) + PW'(dby_reg) + PW'(dcy_reg));
            end
            va_reg <= (accept && opcode == OPC_PIXEL) || (state_reg == ST_DSUM);
            vb_reg <= va_reg;
        end
    end

    // Rebuild datapath: differences, then products.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIFF) begin
            v1_reg  <= ext(sx_reg[0]) - ext(sx_reg[1]);
            v2_reg  <= ext(sy_reg[0]) - ext(sy_reg[1]);
            w1_reg  <= ext(sx_reg[2]) - ext(sx_reg[1]);
            w2_reg  <= ext(sy_reg[2]) - ext(sy_reg[1]);
            v3x_reg <= zx0 - zx1;
            w3x_reg <= zx2 - zx1;
            v3y_reg <= zy0 - zy1;
            w3y_reg <= zy2 - zy1;
        end
        if (state_reg == ST_PROD) begin
            pa1x_reg <= (2*DW)'(v2_reg) * (2*DW)'(w3x_reg);
            pa2x_reg <= (2*DW)'(v3x_reg) * (2*DW)'(w2_reg);
            pb1x_reg <= (2*DW)'(v3x_reg) * (2*DW)'(w1_reg);
            pb2x_reg <= (2*DW)'(v1_reg) * (2*DW)'(w3x_reg);
            pa1y_reg <= (2*DW)'(v2_reg) * (2*DW)'(w3y_reg);
            pa2y_reg <= (2*DW)'(v3y_reg) * (2*DW)'(w2_reg);
            pb1y_reg <= (2*DW)'(v3y_reg) * (2*DW)'(w1_reg);
            pb2y_reg <= (2*DW)'(v1_reg) * (2*DW)'(w3y_reg);
            pc1_reg  <= (2*DW)'(v1_reg) * (2*DW)'(w2_reg);
            pc2_reg  <= (2*DW)'(v2_reg) * (2*DW)'(w1_reg);
        end
        if (state_reg == ST_DPROD) begin
            dax_reg <= TW'(ax_reg) * TW'(ext(sx_reg[0]));
            dbx_reg <= TW'(bx_reg) * TW'(ext(sy_reg[0]));
            dcx_reg <= TW'(c_reg) * TW'(zx0);
            day_reg <= TW'(ay_reg) * TW'(ext(sx_reg[0]));
            dby_reg <= TW'(by_reg) * TW'(ext(sy_reg[0]));
            dcy_reg <= TW'(c_reg) * TW'(zy0);
        end
    end

    // Query stage A takes the pixel beat or the load acknowledge.
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pix_reg   <= 1'b1;
            a_degen_reg <= (c_reg == '0);
            a_px_reg    <= pixel_x;
            a_py_reg    <= pixel_y;
        end else if (state_reg == ST_DSUM) begin
            a_pix_reg   <= 1'b0;
            a_degen_reg <= (c_reg == '0);
        end
    end

    // Stage B: plane products and edge tests.
    always_ff @(posedge aclk) begin
        b_pix_reg   <= a_pix_reg;
        b_degen_reg <= a_degen_reg;
        b_pax_reg   <= TW'(ax_reg) * TW'(ext(a_px_reg));
        b_pby_reg   <= TW'(bx_reg) * TW'(ext(a_py_reg));
        b_pay_reg   <= TW'(ay_reg) * TW'(ext(a_px_reg));
        b_pby2_reg  <= TW'(by_reg) * TW'(ext(a_py_reg));
        b_e0_reg    <= edge_cross(sx_reg[0], sy_reg[0], sx_reg[1], sy_reg[1],
                                  a_px_reg, a_py_reg);
        b_e1_reg    <= edge_cross(sx_reg[1], sy_reg[1], sx_reg[2], sy_reg[2],
                                  a_px_reg, a_py_reg);
        b_e2_reg    <= edge_cross(sx_reg[2], sy_reg[2], sx_reg[0], sy_reg[0],
                                  a_px_reg, a_py_reg);
    end

    // Numerators and the inside decision go into the queue.
    always_comb begin
        pos_all = !b_e0_reg[EW-1] && !b_e1_reg[EW-1] && !b_e2_reg[EW-1];
        neg_all = (b_e0_reg[EW-1] || b_e0_reg == '0) &&
                  (b_e1_reg[EW-1] || b_e1_reg == '0) &&
                  (b_e2_reg[EW-1] || b_e2_reg == '0);
        push              = vb_reg;
        push_flags.pix    = b_pix_reg;
        push_flags.degen  = b_degen_reg;
        push_flags.in_tri = pos_all || neg_all;
        push_nx = -(NW'(b_pax_reg) + NW'(b_pby_reg) + NW'(dpx_reg));
        push_ny = -(NW'(b_pay_reg) + NW'(b_pby2_reg) + NW'(dpy_reg));
        push_c  = c_reg;
    end

endmodule

// ===== design/tfi_back.sv =====
module tfi_back
    import tfi_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int AW         = 2 * DEF_COORD_BITS + 5,
    parameter int NW         = 3 * DEF_COORD_BITS + 11
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  item_flags_t              q_flags,
    input  logic signed [NW-1:0]     q_nx,
    input  logic signed [NW-1:0]     q_ny,
    input  logic signed [AW-1:0]     q_c,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     res_pix,
    output logic                     res_inside,
    output logic                     res_degen,
    output logic signed [FLOW_W-1:0] res_flow_x,
    output logic signed [FLOW_W-1:0] res_flow_y
);

    localparam int QW = (COORD_BITS + FRAC_BITS < FLOW_W - 1) ?
                        COORD_BITS + FRAC_BITS : FLOW_W - 1;
    localparam longint LIM_FULL = ((longint'(1) << COORD_BITS) - 1) << FRAC_BITS;
    localparam longint LIM      = (LIM_FULL > FLOW_CAP) ? FLOW_CAP : LIM_FULL;
    localparam int RW_N = NW + FRAC_BITS + 2;
    localparam int RW_D = AW + QW + 1;
    localparam int RW   = ((RW_N > RW_D) ? RW_N : RW_D) + 1;

    // One quotient bit per stage in each of the two lanes.
    logic              v_reg     [QW+1];
    item_flags_t       flags_reg [QW+1];
    logic [RW-1:0]     d_reg     [QW];
    logic [RW-1:0]     rem_reg   [2][QW];
    logic [QW-1:0]     q_reg     [2][QW+1];
    logic              neg_reg   [2][QW+1];
    logic              ovf_reg   [2][QW+1];
    logic              out_valid_reg;
    item_flags_t       out_flags_reg;
    logic [FLOW_W-1:0] out_flow_reg [2];

    logic              adv;
    logic [NW-1:0]     un [2];
    logic [AW-1:0]     uc;
    logic [QW-1:0]     mag [2];
    logic              show;

    // Whole pipeline moves when the output register is free.
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && q_valid;

    // Magnitudes of the numerators and of the area term.
    always_comb begin
        un[0] = q_nx[NW-1] ? NW'(-q_nx) : NW'(q_nx);
        un[1] = q_ny[NW-1] ? NW'(-q_ny) : NW'(q_ny);
        uc    = q_c[AW-1] ? AW'(-q_c) : AW'(q_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) begin
                v_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= q_valid;
            for (int k = 0; k < QW; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
            out_valid_reg <= v_reg[QW];
        end
    end

    // Rounded quotient: floor((2*|n|*2^F + |c|) / (2*|c|)), restoring form.
    always_ff @(posedge aclk) begin
        if (adv) begin
            flags_reg[0] <= q_flags;
            d_reg[0]     <= RW'(uc) << 1;
            for (int l = 0; l < 2; l++) begin
                rem_reg[l][0] <= (RW'(un[l]) << (FRAC_BITS + 1)) + RW'(uc);
                q_reg[l][0]   <= '0;
                ovf_reg[l][0] <= 1'b0;
            end
            neg_reg[0][0] <= q_nx[NW-1] ^ q_c[AW-1];
            neg_reg[1][0] <= q_ny[NW-1] ^ q_c[AW-1];
            for (int k = 0; k < QW; k++) begin
                flags_reg[k+1] <= flags_reg[k];
                if (k + 1 < QW) begin
                    d_reg[k+1] <= d_reg[k];
                end
                for (int l = 0; l < 2; l++) begin
                    neg_reg[l][k+1] <= neg_reg[l][k];
                    ovf_reg[l][k+1] <= ovf_reg[l][k] ||
                                       ((k == 0) && (rem_reg[l][k] >= (d_reg[k] << QW)));
                    if (rem_reg[l][k] >= (d_reg[k] << (QW - 1 - k))) begin
                        q_reg[l][k+1] <= q_reg[l][k] | (QW'(1) << (QW - 1 - k));
                        if (k + 1 < QW) begin
                            rem_reg[l][k+1] <= rem_reg[l][k] - (d_reg[k] << (QW - 1 - k));
                        end
                    end else begin
                        q_reg[l][k+1] <= q_reg[l][k];
                        if (k + 1 < QW) begin
                            rem_reg[l][k+1] <= rem_reg[l][k];
                        end
                    end
                end
            end
        end
    end

    // Saturate, apply sign, and blank acknowledges and degenerate answers.
    always_comb begin
        show = flags_reg[QW].pix && !flags_reg[QW].degen;
        for (int l = 0; l < 2; l++) begin
            if (ovf_reg[l][QW] || q_reg[l][QW] > QW'(LIM)) begin
                mag[l] = QW'(LIM);
            end else begin
                mag[l] = q_reg[l][QW];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_flags_reg.pix    <= flags_reg[QW].pix;
            out_flags_reg.degen  <= flags_reg[QW].degen;
            out_flags_reg.in_tri <= show && flags_reg[QW].in_tri;
            for (int l = 0; l < 2; l++) begin
                if (!show) begin
                    out_flow_reg[l] <= '0;
                end else if (neg_reg[l][QW]) begin
                    out_flow_reg[l] <= -FLOW_W'(mag[l]);
                end else begin
                    out_flow_reg[l] <= FLOW_W'(mag[l]);
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign res_pix    = out_flags_reg.pix;
    assign res_inside = out_flags_reg.in_tri;
    assign res_degen  = out_flags_reg.degen;
    assign res_flow_x = signed'(out_flow_reg[0]);
    assign res_flow_y = signed'(out_flow_reg[1]);

endmodule

// ===== design/triangle_flow_interpolator_core.sv =====
// Pixel query beats are taken one per cycle while the queue has room and no rebuild runs;
// each result passes front stages A and B, the queue and the quotient pipeline.
// A corner load holds s_tready low while the sequencer rebuilds both planes;
// its acknowledge then follows the same path as a pixel result.
// The quotient pipeline resolves one bit per stage in each lane; load stalls come from the rebuild.
// aresetn is synchronous: it clears the corners, planes and all valid state.
module triangle_flow_interpolator_core
    import tfi_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // vertex_slot, src_x, src_y, dst_x, dst_y, pixel_x, pixel_y, zero fill
    input  logic [((2 + 6 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  logic                                    s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // inside_res, degenerate, flow_x, flow_y
    output logic [M_TDATA_W-1:0]                    m_tdata,
    // is_pixel_result
    output logic                                    m_tuser
);

    localparam int CB = COORD_BITS;
    localparam int AW = 2 * CB + 5;
    localparam int NW = 3 * CB + 11;
    localparam int QW = 3 + 2 * NW + AW;

    item_flags_t              push_flags, head_flags;
    logic                     push, pop, q_not_empty;
    logic signed [NW-1:0]     push_nx, push_ny, head_nx, head_ny;
    logic signed [AW-1:0]     push_c, head_c;
    logic [QW-1:0]            head_data;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    logic                     res_inside, res_degen;
    logic signed [FLOW_W-1:0] res_flow_x, res_flow_y;

    // Front end: corner store, plane rebuild, per-pixel products.
    tfi_front #(
        .COORD_BITS (COORD_BITS),
        .QDEPTH     (QUEUE_DEPTH),
        .AW         (AW),
        .NW         (NW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .opcode      (s_tuser),
        .vertex_slot (s_tdata[1:0]),
        .src_x       (s_tdata[2 +: CB]),
        .src_y       (s_tdata[2 + CB +: CB]),
        .dst_x       (s_tdata[2 + 2 * CB +: CB]),
        .dst_y       (s_tdata[2 + 3 * CB +: CB]),
        .pixel_x     (s_tdata[2 + 4 * CB +: CB]),
        .pixel_y     (s_tdata[2 + 5 * CB +: CB]),
        .q_count     (q_count),
        .push        (push),
        .push_flags  (push_flags),
        .push_nx     (push_nx),
        .push_ny     (push_ny),
        .push_c      (push_c)
    );

    // Short queue between front and back.
    tfi_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_flags, push_nx, push_ny, push_c}),
        .pop       (pop),
        .head_data (head_data),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign {head_flags, head_nx, head_ny, head_c} = head_data;

    // Back end: rounded, saturated division by the area term.
    tfi_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .AW         (AW),
        .NW         (NW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_not_empty),
        .q_flags    (head_flags),
        .q_nx       (head_nx),
        .q_ny       (head_ny),
        .q_c        (head_c),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .res_pix    (m_tuser),
        .res_inside (res_inside),
        .res_degen  (res_degen),
        .res_flow_x (res_flow_x),
        .res_flow_y (res_flow_y)
    );

    assign m_tdata = {res_flow_y, res_flow_x, res_degen, res_inside};

endmodule

// ===== design/tfi_checker.sv =====
module tfi_checker
    import tfi_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    localparam logic [FLOW_W-1:0] FLOW_MOST_NEG = {1'b1, {(FLOW_W - 1){1'b0}}};

    // A result beat is held until it is taken.
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A load acknowledge carries no inside flag and no displacement.
    a_ack_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tdata[0] && m_tdata[M_TDATA_W-1:2] == '0)
        else $error("load acknowledge carries values");

    // A degenerate answer carries no inside flag and no displacement.
    a_degen_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && m_tdata[1] |-> !m_tdata[0] && m_tdata[M_TDATA_W-1:2] == '0)
        else $error("degenerate answer carries values");

    // Saturation keeps both displacements off the most negative code.
    a_flow_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2 +: FLOW_W] != FLOW_MOST_NEG &&
                     m_tdata[2 + FLOW_W +: FLOW_W] != FLOW_MOST_NEG)
        else $error("displacement outside saturation range");

endmodule

bind triangle_flow_interpolator_core tfi_checker u_tfi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/triangle_flow_interpolator_core_test.sv =====
`timescale 1ns / 1ps

module triangle_flow_interpolator_core_test;
    import tfi_pkg::*;

    localparam int CB = DEF_COORD_BITS;
    localparam int FB = DEF_FRAC_BITS;
    localparam int S_W = ((2 + 6 * CB + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic           opc;
        logic [1:0]     slot;
        logic [CB-1:0]  sx, sy, dx, dy, px, py;
    } tri_item_t;

    typedef struct {
        logic                     pix;
        logic                     in_tri;
        logic                     degen;
        logic signed [FLOW_W-1:0] fx, fy;
    } flow_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    triangle_flow_interpolator_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Predictor state: corner coordinates, plane terms and the shared area term.
    longint csx[3], csy[3], cdx[3], cdy[3];
    longint xa, xb, xd, ya, yb, yd, area2;

    tri_item_t    pending_items[$];
    flow_result_t expected_flows[$];
    int  errors = 0;
    int  accepted_in = 0, received = 0, pixels_in = 0, inside_seen = 0;
    int  send_idle_pct = 0, recv_stall_pct = 0;
    int  hold_off = 0;
    bit  stim_done = 0;
    bit  in_taken = 0;
    int  quiet_cycles = 0;

    // Plane a*x + b*y + c*z + d = 0 through the three stored corners.
    function automatic void plane_terms(input longint z0, z1, z2,
                                        output longint a, b, d, c);
        longint v1, v2, v3, w1, w2, w3;
        v1 = csx[0] - csx[1]; v2 = csy[0] - csy[1]; v3 = z0 - z1;
        w1 = csx[2] - csx[1]; w2 = csy[2] - csy[1]; w3 = z2 - z1;
        a = v2 * w3 - v3 * w2;
        b = v3 * w1 - v1 * w3;
        c = v1 * w2 - v2 * w1;
        d = -a * csx[0] - b * csy[0] - c * z0;
    endfunction

    // Rounded, saturated n * 2^FB / c as a 19-bit word.
    function automatic logic [FLOW_W-1:0] fixed_div(input longint n, input longint c);
        bit neg;
        longint un, uc, lim, q, r, rs, mag, rem;
        neg = (n < 0) != (c < 0);
        un = n < 0 ? -n : n;
        uc = c < 0 ? -c : c;
        lim = ((64'sd1 << CB) - 1) << FB;
        if (lim > FLOW_CAP) lim = FLOW_CAP;
        q = un / uc;
        r = un % uc;
        if (q > (lim >> FB)) begin
            mag = lim;
        end else begin
            rs = r << FB;
            mag = (q << FB) + rs / uc;
            rem = rs % uc;
            if (rem >= uc - rem) mag++;
            if (mag > lim) mag = lim;
        end
        if (neg) mag = -mag;
        return mag[FLOW_W-1:0];
    endfunction

    function automatic longint edge_sign(input int u, input int v, input longint x, y);
        return (csx[v] - csx[u]) * (y - csy[u]) - (csy[v] - csy[u]) * (x - csx[u]);
    endfunction

    // Update the predictor with one accepted beat and queue its result.
    task automatic predict_flow(input tri_item_t it);
        flow_result_t r;
        longint dummy, e0, e1, e2, x, y;
        r = '{pix: it.opc, in_tri: 1'b0, degen: 1'b0, fx: '0, fy: '0};
        if (it.opc == OPC_LOAD) begin
            if (it.slot < 3) begin
                csx[it.slot] = it.sx; csy[it.slot] = it.sy;
                cdx[it.slot] = it.dx; cdy[it.slot] = it.dy;
                plane_terms(cdx[0] - csx[0], cdx[1] - csx[1], cdx[2] - csx[2],
                            xa, xb, xd, area2);
                plane_terms(cdy[0] - csy[0], cdy[1] - csy[1], cdy[2] - csy[2],
                            ya, yb, yd, dummy);
            end
            r.degen = (area2 == 0);
        end else if (area2 == 0) begin
            r.degen = 1'b1;
        end else begin
            x = it.px; y = it.py;
            e0 = edge_sign(0, 1, x, y);
            e1 = edge_sign(1, 2, x, y);
            e2 = edge_sign(2, 0, x, y);
            r.in_tri = (e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0);
            r.fx = fixed_div(-(xa * x + xb * y + xd), area2);
            r.fy = fixed_div(-(ya * x + yb * y + yd), area2);
        end
        expected_flows.push_back(r);
    endtask

    // Driver: offers the next pending beat at the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !in_taken) begin
                // hold the beat until it is taken
            end else if (pending_items.size() > 0 &&
                         $urandom_range(99, 0) >= send_idle_pct) begin
                tri_item_t it;
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.opc;
                s_tdata  <= S_W'({it.py, it.px, it.dy, it.dx, it.sy, it.sx, it.slot});
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready pattern, with a long hold-off counted here when requested.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                hold_off <= hold_off - 1;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // Monitor: input acceptance feeds the predictor, results are checked in order.
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            quiet_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ?
                            0 : quiet_cycles + 1;
            if (s_tvalid && s_tready) begin
                tri_item_t it;
                it.opc = s_tuser;
                {it.py, it.px, it.dy, it.dx, it.sy, it.sx, it.slot} = s_tdata[2 + 6 * CB - 1:0];
                predict_flow(it);
                accepted_in++;
                if (it.opc == OPC_PIXEL) pixels_in++;
            end
            if (m_tvalid && m_tready) begin
                flow_result_t e;
                received++;
                if (expected_flows.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = expected_flows.pop_front();
                    if (m_tuser !== e.pix) begin
                        $error("is_pixel_result: expected %0d, got %0d", e.pix, m_tuser);
                        errors++;
                    end
                    if (m_tdata[0] !== e.in_tri) begin
                        $error("inside_res: expected %0d, got %0d", e.in_tri, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[1] !== e.degen) begin
                        $error("degenerate: expected %0d, got %0d", e.degen, m_tdata[1]);
                        errors++;
                    end
                    if (m_tdata[2 +: FLOW_W] !== e.fx) begin
                        $error("flow_x: expected %0d, got %0d", e.fx,
                               $signed(m_tdata[2 +: FLOW_W]));
                        errors++;
                    end
                    if (m_tdata[2 + FLOW_W +: FLOW_W] !== e.fy) begin
                        $error("flow_y: expected %0d, got %0d", e.fy,
                               $signed(m_tdata[2 + FLOW_W +: FLOW_W]));
                        errors++;
                    end
                    if (e.in_tri) inside_seen++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic tri_item_t corner_load(input int slot, input int sx, sy, dx, dy);
        tri_item_t it;
        it = '{opc: OPC_LOAD, slot: slot[1:0], sx: sx[CB-1:0], sy: sy[CB-1:0],
               dx: dx[CB-1:0], dy: dy[CB-1:0], px: CB'($urandom), py: CB'($urandom)};
        return it;
    endfunction

    function automatic tri_item_t pixel_query(input int px, py);
        tri_item_t it;
        it = '{opc: OPC_PIXEL, slot: 2'($urandom), sx: CB'($urandom), sy: CB'($urandom),
               dx: CB'($urandom), dy: CB'($urandom), px: px[CB-1:0], py: py[CB-1:0]};
        return it;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(9, 0))
            0: return 0;
            1: return (1 << CB) - 1;
            default: return $urandom_range((1 << CB) - 1, 0);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_flows.size() > 0)
            @(posedge aclk);
    endtask

    // One random triangle followed by a burst of queries, or some noise.
    task automatic queue_random_group();
        int cx[3], cy[3], n;
        if ($urandom_range(9, 0) == 0) begin
            if ($urandom_range(1, 0))
                pending_items.push_back(corner_load($urandom_range(3, 0), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord()));
            else
                pending_items.push_back(pixel_query(rand_coord(), rand_coord()));
            return;
        end
        for (int k = 0; k < 3; k++) begin
            cx[k] = rand_coord(); cy[k] = rand_coord();
            pending_items.push_back(corner_load(k, cx[k], cy[k], rand_coord(), rand_coord()));
        end
        n = $urandom_range(12, 4);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3, 0) == 0)
                pending_items.push_back(pixel_query(cx[k % 3], cy[k % 3]));
            else if ($urandom_range(1, 0))
                pending_items.push_back(pixel_query(
                    (cx[0] + cx[1] + cx[2]) / 3 + $urandom_range(8, 0) - 4,
                    (cy[0] + cy[1] + cy[2]) / 3 + $urandom_range(8, 0) - 4));
            else
                pending_items.push_back(pixel_query(rand_coord(), rand_coord()));
        end
    endtask

    initial begin
        int m = (1 << CB) - 1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: degenerate after reset, unused slot, extremes, edge and outside pixels.
        pending_items.push_back(pixel_query(5, 5));
        pending_items.push_back(corner_load(3, m, m, m, m));
        pending_items.push_back(corner_load(0, 0, 0, m, m));
        pending_items.push_back(corner_load(1, m, 0, 0, m));
        pending_items.push_back(corner_load(2, 0, m, m, 0));
        pending_items.push_back(pixel_query(0, 0));
        pending_items.push_back(pixel_query(m, m));
        pending_items.push_back(pixel_query(512, 0));
        pending_items.push_back(pixel_query(100, 100));
        pending_items.push_back(pixel_query(m, 0));
        pending_items.push_back(corner_load(2, 0, m, 0, m));
        pending_items.push_back(pixel_query(m, m));
        pending_items.push_back(corner_load(0, 0, 0, 0, 0));
        pending_items.push_back(corner_load(1, 1, 0, m, m));
        pending_items.push_back(corner_load(2, 0, 1, m, 0));
        pending_items.push_back(pixel_query(m, m));
        pending_items.push_back(pixel_query(0, m));
        pending_items.push_back(corner_load(1, 0, 0, 5, 5));
        pending_items.push_back(pixel_query(3, 3));
        wait_drained();

        // Random phases under different idling patterns.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                3: begin send_idle_pct = 16; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (phase == 4) hold_off = 300;
            while (pending_items.size() < 330) queue_random_group();
            wait_drained();
        end
        stim_done = 1;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d input beats (%0d pixel queries), %0d results, %0d inside",
                 accepted_in, pixels_in, received, inside_seen);
        if (errors == 0 && expected_flows.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
